@@ hw/rtl/fifo_queue_search_delete_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef FIFO_QUEUE_SEARCH_DELETE_MACROS_SVH
`define FIFO_QUEUE_SEARCH_DELETE_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain invariant, checked at every edge outside reset
`define FQSD_ASSERT_HOLD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence in the cycle after the trigger
`define FQSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FQSD_ASSERT_HOLD(lbl, clk, rst_n, prop, msg)
`define FQSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/fqsd_pkg.sv @@
// ----------------------------------------------------------------------------
// fqsd_pkg
// types and constants for the searchable fifo queue
// ----------------------------------------------------------------------------
package fqsd_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH   = 3'd0,
        K_POP    = 3'd1,
        K_PEEK   = 3'd2,
        K_FIND   = 3'd3,
        K_DELETE = 3'd4,
        K_CLEAR  = 3'd5
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // command broadcast to every cell
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              del;
        logic [DATA_W-1:0] key;
    } t_cell_ctl;

endpackage

@@ hw/rtl/fqsd_ifs.sv @@
// ----------------------------------------------------------------------------
// fqsd_in_if / fqsd_out_if
// valid/ready channels for operations and results
// ----------------------------------------------------------------------------
interface fqsd_in_if;
    import fqsd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] operand_value;

    modport source (output valid, output kind, output operand_value, input ready);
    modport sink   (input valid, input kind, input operand_value, output ready);
endinterface

interface fqsd_out_if;
    import fqsd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output result_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input result_value, input status, input occupancy,
                    output ready);
endinterface

@@ hw/rtl/fifo_queue_search_delete.sv @@
// result: registered, valid in the cycle after the operation transfers
// throughput: one operation per cycle while results are taken, set by the compare and shift in each cell
// a result waiting in the output register stalls input only if it is not taken
// reset (synchronous, active low) empties the queue and drops any pending result
// entry contents are not reset; only entries below the count are ever read
// ----------------------------------------------------------------------------
// fifo_queue_search_delete
// bounded fifo with find and delete-first-match, built as a row of cells
// ----------------------------------------------------------------------------
`include "fifo_queue_search_delete_macros.svh"

module fifo_queue_search_delete (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fqsd_in_if.sink    i_op,
    fqsd_out_if.source o_res
);
    import fqsd_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_res_value;
    logic [DATA_W-1:0] n_res_value;
    logic [STAT_W-1:0] r_status;
    t_status           n_status;
    logic [OCC_W-1:0]  r_occ;
    logic [31:0]       count_wide;

    logic              fire;
    logic              full;
    logic              empty;
    logic              found;
    t_cell_ctl         ctl;

    logic [DEPTH:0]    hit_chain;
    logic [DATA_W-1:0] cell_data [DEPTH];

    assign i_op.ready = !r_out_valid || o_res.ready;
    assign fire       = i_op.valid && i_op.ready;
    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);
    assign found      = hit_chain[DEPTH];

    assign ctl.push = fire && (i_op.kind == K_PUSH) && !full;
    assign ctl.pop  = fire && (i_op.kind == K_POP) && !empty;
    assign ctl.del  = fire && (i_op.kind == K_DELETE);
    assign ctl.key  = i_op.operand_value;

    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] next_data;
        if (g == DEPTH - 1) begin : g_last
            assign next_data = cell_data[g];
        end else begin : g_mid
            assign next_data = cell_data[g + 1];
        end

        fqsd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_valid (CNT_W'(g) < r_count),
            .i_tail  (CNT_W'(g) == r_count),
            .i_next  (next_data),
            .i_hit   (hit_chain[g]),
            .o_hit   (hit_chain[g + 1]),
            .o_data  (cell_data[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_res_value = '0;
        n_status    = ST_OK;
        case (i_op.kind)
            K_PUSH: begin
                if (full) n_status = ST_FULL;
                else      n_count  = r_count + 1'b1;
            end
            K_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_res_value = cell_data[0];
                    n_count     = r_count - 1'b1;
                end
            end
            K_PEEK: begin
                if (empty) n_status    = ST_EMPTY;
                else       n_res_value = cell_data[0];
            end
            K_FIND: begin
                if (!found) n_status = ST_NOTFOUND;
            end
            K_DELETE: begin
                if (!found) n_status = ST_NOTFOUND;
                else        n_count  = r_count - 1'b1;
            end
            K_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // occupancy field holds the whole count after the operation, as OCC_W equals CNT_W
    assign count_wide = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res_value <= n_res_value;
            r_status    <= n_status;
            r_occ       <= count_wide[OCC_W-1:0];
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_res_value;
    assign o_res.status       = r_status;
    assign o_res.occupancy    = r_occ;

    `FQSD_ASSERT_HOLD(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "count past depth")
    `FQSD_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, ctl.push, r_count == CNT_W'($past(r_count) + 1'b1), "push did not grow count")
    `FQSD_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, fire && (i_op.kind == K_CLEAR), r_count == '0, "clear left entries")
    `FQSD_ASSERT_NEXT(a_miss_keeps, i_clk, i_rst_n, ctl.del && !found, $stable(r_count), "delete miss changed count")
    `FQSD_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, fire, r_out_valid, "transfer gave no result")

endmodule

@@ hw/rtl/fqsd_cell.sv @@
// ----------------------------------------------------------------------------
// fqsd_cell
// one queue entry: compare against the key, shift up from the neighbour
// ----------------------------------------------------------------------------
module fqsd_cell (
    input  logic                              i_clk,
    input  fqsd_pkg::t_cell_ctl               i_ctl,
    input  logic                              i_valid,
    input  logic                              i_tail,
    input  logic [fqsd_pkg::DATA_W-1:0]       i_next,
    input  logic                              i_hit,
    output logic                              o_hit,
    output logic [fqsd_pkg::DATA_W-1:0]       o_data
);
    import fqsd_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // hit travels towards the tail: everything at or after the first match moves up
    assign o_hit  = i_hit | (i_valid && (r_data == i_ctl.key));
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.pop || (i_ctl.del && o_hit)) begin
            n_data = i_next;
        end else if (i_ctl.push && i_tail) begin
            n_data = i_ctl.key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule
